// File: design/assert_macros.svh
// Assertion macros shared by the segment/box distance RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define SBD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define SBD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/sbd_pkg.sv
// Package for the segment/box distance block: widths, constants and unit types.
// No dependencies.
`default_nettype none
package sbd_pkg;

  localparam int ITER_BOUND = 64;
  localparam int ITER_W     = 7;
  localparam int LEN_W      = 34;
  localparam int SQ_W       = 66;
  localparam int PROD_W     = 68;

  // Inverse golden ratio in Q0.32.
  localparam logic [LEN_W-1:0] INVPHI_Q32 = 34'h0_9E37_79B9;

  // Configuration register indexes.
  localparam logic [7:0] CFG_ITER_LIMIT = 8'd0;
  localparam logic [7:0] CFG_TOLERANCE  = 8'd1;

  // Request to the shared serial root/divide unit.
  typedef struct packed {
    logic              start;
    logic              is_sqrt;
    logic [PROD_W-1:0] operand;
    logic [LEN_W-1:0]  divisor;
  } sbd_unit_req_t;

  // Response from the shared serial unit.
  typedef struct packed {
    logic             done;
    logic [LEN_W-1:0] result;
  } sbd_unit_rsp_t;

endpackage
`default_nettype wire

// File: design/sbd_channels.sv
// Handshake channel interfaces: query input, result output and register writes.
// Depends on nothing.
`default_nettype none
interface sbd_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] start_x, start_y, start_z;
  logic signed [31:0] end_x, end_y, end_z;
  logic signed [31:0] lower_x, lower_y, lower_z;
  logic signed [31:0] upper_x, upper_y, upper_z;
  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  lower_x, lower_y, lower_z, upper_x, upper_y, upper_z, input ready);
  modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                lower_x, lower_y, lower_z, upper_x, upper_y, upper_z, output ready);
endinterface

interface sbd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] box_point_x, box_point_y, box_point_z;
  logic signed [31:0] seg_point_x, seg_point_y, seg_point_z;
  logic        [31:0] gap;
  modport source (output valid, box_point_x, box_point_y, box_point_z,
                  seg_point_x, seg_point_y, seg_point_z, gap, input ready);
  modport sink (input valid, box_point_x, box_point_y, box_point_z,
                seg_point_x, seg_point_y, seg_point_z, gap, output ready);
endinterface

interface sbd_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: design/sbd_serial.sv
// Shared serial unit: floor square root or restoring division, one bit per cycle.
// Depends on sbd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module sbd_serial
  import sbd_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  sbd_unit_req_t      req,
  output sbd_unit_rsp_t      rsp
);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic                sqrt_r, sqrt_nxt;
  logic [5:0]          cnt_r, cnt_nxt;
  logic [PROD_W-1:0]   shf_r, shf_nxt;
  logic [36:0]         rem_r, rem_nxt;
  logic [LEN_W-1:0]    root_r, root_nxt;
  logic [LEN_W-1:0]    dvs_r, dvs_nxt;
  logic [36:0]         rem_sh, trial;
  logic                ge;

  // One step: bring down the next digit, compare against the trial, subtract.
  always_comb begin
    rem_sh = sqrt_r ? {rem_r[34:0], shf_r[PROD_W-1 -: 2]} : {rem_r[35:0], shf_r[PROD_W-1]};
    trial  = sqrt_r ? {1'b0, root_r, 2'b01} : {3'b000, dvs_r};
    ge     = (rem_sh >= trial);

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sqrt_nxt = sqrt_r;
    cnt_nxt  = cnt_r;
    shf_nxt  = shf_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    dvs_nxt  = dvs_r;

    if (req.start) begin
      busy_nxt = 1'b1;
      sqrt_nxt = req.is_sqrt;
      root_nxt = '0;
      dvs_nxt  = req.divisor;
      if (req.is_sqrt) begin
        rem_nxt = '0;
        shf_nxt = req.operand;
        cnt_nxt = 6'd34;
      end else begin
        // The quotient fits 33 bits, so the top bits start as the remainder.
        rem_nxt = {3'b000, req.operand[66:33]};
        shf_nxt = {req.operand[32:0], 35'd0};
        cnt_nxt = 6'd33;
      end
    end else if (busy_r) begin
      rem_nxt  = ge ? (rem_sh - trial) : rem_sh;
      root_nxt = {root_r[LEN_W-2:0], ge};
      shf_nxt  = sqrt_r ? {shf_r[PROD_W-3:0], 2'b00} : {shf_r[PROD_W-2:0], 1'b0};
      cnt_nxt  = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    sqrt_r <= sqrt_nxt;
    cnt_r  <= cnt_nxt;
    shf_r  <= shf_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = root_r;

  `SBD_ASSERT_ALWAYS(a_no_start_busy, !(req.start && busy_r), "start while unit busy")
  `SBD_ASSERT_NEXT(a_done_pulse, done_r, !done_r, "done held longer than one cycle")
  `SBD_ASSERT_NEXT(a_start_busy, req.start, busy_r && !done_r, "start did not launch unit")

endmodule
`default_nettype wire

// File: design/segment_box_distance_golden.sv
// Sequence: a 34-step root for the length, up to 64 search steps, then a 34-step root
// for the gap; a short segment skips the search. Each probe runs three 33-step
// divisions on the shared serial unit.
// Throughput: one query at a time; a new request is taken once the result is taken.
// Reset: synchronous, active low; iteration_limit returns to 50 and tolerance to 66.
`default_nettype none
`include "assert_macros.svh"
module segment_box_distance_golden
  import sbd_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  sbd_in_if.sink    in_req,
  sbd_out_if.source out_rsp,
  sbd_cfg_if.sink   cfg_wr
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ_MUL, ST_SQ_ACC, ST_ROOT, ST_ROOT_WAIT, ST_K_MUL, ST_K_SET,
    ST_POS_MUL, ST_POS_GO, ST_POS_WAIT, ST_DST_MUL, ST_DST_ACC, ST_OUT
  } state_t;

  typedef enum logic [1:0] {PR_C, PR_D, PR_FIN} probe_t;

  state_t             state_r, state_nxt;
  probe_t             probe_r, probe_nxt;
  logic [ITER_W-1:0]  limit_r, limit_nxt;
  logic [31:0]        tol_r, tol_nxt;
  logic signed [31:0] p1_r [3], p1_nxt [3];
  logic [32:0]        dmag_r [3], dmag_nxt [3];
  logic               dneg_r [3], dneg_nxt [3];
  logic signed [31:0] lo_r [3], lo_nxt [3];
  logic signed [31:0] hi_r [3], hi_nxt [3];
  logic signed [31:0] pt_r [3], pt_nxt [3];
  logic signed [31:0] bx_r [3], bx_nxt [3];
  logic [LEN_W-1:0]   len_r, len_nxt, a_r, a_nxt, b_r, b_nxt;
  logic [LEN_W-1:0]   c_r, c_nxt, d_r, d_nxt, s_r, s_nxt;
  logic [SQ_W-1:0]    acc_r, acc_nxt, fc_r, fc_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [1:0]         axis_r, axis_nxt;
  logic [ITER_W-1:0]  iter_r, iter_nxt, steps_r, steps_nxt;
  logic               gap_ph_r, gap_ph_nxt;
  logic [31:0]        gap_r, gap_nxt;

  sbd_unit_req_t      unit_req;
  sbd_unit_rsp_t      unit_rsp;

  logic signed [31:0] in_s [3], in_e [3], in_lo [3], in_hi [3];
  logic signed [32:0] dir  [3];
  logic [LEN_W-1:0]   mul_a, mul_b;
  logic signed [31:0] cur_pt, cur_bx;
  logic signed [32:0] diff;
  logic [31:0]        dmag_cur;
  logic [SQ_W-1:0]    acc_sum;
  logic [LEN_W-1:0]   k_val, na, nb, root;
  logic [LEN_W:0]     mid_sum;
  logic [32:0]        quo;
  logic signed [33:0] pos;
  logic [ITER_W-1:0]  steps_cap;

  sbd_serial u_serial (
    .clk (clk),
    .rst_n (rst_n),
    .req (unit_req),
    .rsp (unit_rsp)
  );

  // Input fields as per-axis arrays, and the direction vector.
  always_comb begin
    in_s[0] = in_req.start_x;  in_s[1] = in_req.start_y;  in_s[2] = in_req.start_z;
    in_e[0] = in_req.end_x;    in_e[1] = in_req.end_y;    in_e[2] = in_req.end_z;
    in_lo[0] = in_req.lower_x; in_lo[1] = in_req.lower_y; in_lo[2] = in_req.lower_z;
    in_hi[0] = in_req.upper_x; in_hi[1] = in_req.upper_y; in_hi[2] = in_req.upper_z;
    for (int i = 0; i < 3; i++) begin
      dir[i] = 33'(in_e[i]) - 33'(in_s[i]);
    end
  end

  // Clamp of the current axis point to the box; the upper test wins.
  always_comb begin
    cur_pt = pt_r[axis_r];
    if (cur_pt > hi_r[axis_r]) begin
      cur_bx = hi_r[axis_r];
    end else if (cur_pt < lo_r[axis_r]) begin
      cur_bx = lo_r[axis_r];
    end else begin
      cur_bx = cur_pt;
    end
    diff     = 33'(cur_pt) - 33'(cur_bx);
    dmag_cur = diff[32] ? 32'(-diff) : diff[31:0];
  end

  // Operand selection for the one shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_SQ_MUL: begin
        mul_a = {1'b0, dmag_r[axis_r]};
        mul_b = {1'b0, dmag_r[axis_r]};
      end
      ST_K_MUL: begin
        mul_a = b_r - a_r;
        mul_b = INVPHI_Q32;
      end
      ST_POS_MUL: begin
        mul_a = s_r;
        mul_b = {1'b0, dmag_r[axis_r]};
      end
      ST_DST_MUL: begin
        mul_a = {2'b00, dmag_cur};
        mul_b = {2'b00, dmag_cur};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    probe_nxt  = probe_r;
    limit_nxt  = limit_r;
    tol_nxt    = tol_r;
    p1_nxt     = p1_r;
    dmag_nxt   = dmag_r;
    dneg_nxt   = dneg_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    pt_nxt     = pt_r;
    bx_nxt     = bx_r;
    len_nxt    = len_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    c_nxt      = c_r;
    d_nxt      = d_r;
    s_nxt      = s_r;
    acc_nxt    = acc_r;
    fc_nxt     = fc_r;
    prod_nxt   = prod_r;
    axis_nxt   = axis_r;
    iter_nxt   = iter_r;
    steps_nxt  = steps_r;
    gap_ph_nxt = gap_ph_r;
    gap_nxt    = gap_r;
    unit_req   = '0;

    acc_sum   = acc_r + prod_r[SQ_W-1:0];
    k_val     = prod_r[65:32];
    root      = unit_rsp.result;
    quo       = unit_rsp.result[32:0];
    pos       = dneg_r[axis_r] ? (34'(p1_r[axis_r]) - 34'(quo))
                               : (34'(p1_r[axis_r]) + 34'(quo));
    steps_cap = (limit_r > ITER_W'(ITER_BOUND)) ? ITER_W'(ITER_BOUND) : limit_r;
    if (fc_r < acc_sum) begin
      na = a_r;
      nb = d_r;
    end else begin
      na = c_r;
      nb = b_r;
    end
    mid_sum = {1'b0, na} + {1'b0, nb};

    // Register writes.
    if (cfg_wr.valid) begin
      case (cfg_wr.index)
        CFG_ITER_LIMIT: limit_nxt = cfg_wr.data[ITER_W-1:0];
        CFG_TOLERANCE:  tol_nxt   = cfg_wr.data;
        default:        ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (in_req.valid) begin
          for (int i = 0; i < 3; i++) begin
            p1_nxt[i]   = in_s[i];
            dneg_nxt[i] = dir[i][32];
            dmag_nxt[i] = dir[i][32] ? 33'(-dir[i]) : 33'(dir[i]);
            lo_nxt[i]   = in_lo[i];
            hi_nxt[i]   = in_hi[i];
          end
          acc_nxt   = '0;
          axis_nxt  = 2'd0;
          state_nxt = ST_SQ_MUL;
        end
      end
      ST_SQ_MUL: begin
        prod_nxt  = mul_a * mul_b;
        state_nxt = ST_SQ_ACC;
      end
      ST_SQ_ACC: begin
        acc_nxt = acc_sum;
        if (axis_r == 2'd2) begin
          gap_ph_nxt = 1'b0;
          state_nxt  = ST_ROOT;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = ST_SQ_MUL;
        end
      end
      ST_ROOT: begin
        unit_req.start   = 1'b1;
        unit_req.is_sqrt = 1'b1;
        unit_req.operand = {2'b00, acc_r};
        state_nxt        = ST_ROOT_WAIT;
      end
      ST_ROOT_WAIT: begin
        if (unit_rsp.done) begin
          if (gap_ph_r) begin
            gap_nxt   = (root[33:32] != 2'b00) ? '1 : root[31:0];
            state_nxt = ST_OUT;
          end else begin
            len_nxt  = root;
            axis_nxt = 2'd0;
            acc_nxt  = '0;
            if ((root < {2'b00, tol_r}) || (root == '0)) begin
              // Short segment: the start point itself is the segment point.
              pt_nxt    = p1_r;
              probe_nxt = PR_FIN;
              state_nxt = ST_DST_MUL;
            end else begin
              a_nxt     = '0;
              b_nxt     = root;
              iter_nxt  = '0;
              steps_nxt = steps_cap;
              if (steps_cap == '0) begin
                s_nxt     = root >> 1;
                probe_nxt = PR_FIN;
                state_nxt = ST_POS_MUL;
              end else begin
                state_nxt = ST_K_MUL;
              end
            end
          end
        end
      end
      ST_K_MUL: begin
        prod_nxt  = mul_a * mul_b;
        state_nxt = ST_K_SET;
      end
      ST_K_SET: begin
        c_nxt     = b_r - k_val;
        d_nxt     = a_r + k_val;
        s_nxt     = b_r - k_val;
        probe_nxt = PR_C;
        axis_nxt  = 2'd0;
        state_nxt = ST_POS_MUL;
      end
      ST_POS_MUL: begin
        prod_nxt  = mul_a * mul_b;
        state_nxt = ST_POS_GO;
      end
      ST_POS_GO: begin
        unit_req.start   = 1'b1;
        unit_req.is_sqrt = 1'b0;
        unit_req.operand = prod_r;
        unit_req.divisor = len_r;
        state_nxt        = ST_POS_WAIT;
      end
      ST_POS_WAIT: begin
        if (unit_rsp.done) begin
          pt_nxt[axis_r] = pos[31:0];
          if (axis_r == 2'd2) begin
            axis_nxt  = 2'd0;
            acc_nxt   = '0;
            state_nxt = ST_DST_MUL;
          end else begin
            axis_nxt  = axis_r + 2'd1;
            state_nxt = ST_POS_MUL;
          end
        end
      end
      ST_DST_MUL: begin
        bx_nxt[axis_r] = cur_bx;
        prod_nxt       = mul_a * mul_b;
        state_nxt      = ST_DST_ACC;
      end
      ST_DST_ACC: begin
        acc_nxt = acc_sum;
        if (axis_r != 2'd2) begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = ST_DST_MUL;
        end else begin
          axis_nxt = 2'd0;
          case (probe_r)
            PR_C: begin
              fc_nxt    = acc_sum;
              s_nxt     = d_r;
              probe_nxt = PR_D;
              state_nxt = ST_POS_MUL;
            end
            PR_D: begin
              a_nxt    = na;
              b_nxt    = nb;
              iter_nxt = iter_r + ITER_W'(1);
              if (((nb - na) < {2'b00, tol_r}) || ((iter_r + ITER_W'(1)) == steps_r)) begin
                s_nxt     = mid_sum[LEN_W:1];
                probe_nxt = PR_FIN;
                state_nxt = ST_POS_MUL;
              end else begin
                state_nxt = ST_K_MUL;
              end
            end
            default: begin
              gap_ph_nxt = 1'b1;
              state_nxt  = ST_ROOT;
            end
          endcase
        end
      end
      ST_OUT: begin
        if (out_rsp.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      limit_r <= 7'd50;
      tol_r   <= 32'd66;
    end else begin
      state_r <= state_nxt;
      limit_r <= limit_nxt;
      tol_r   <= tol_nxt;
    end
    probe_r  <= probe_nxt;
    p1_r     <= p1_nxt;
    dmag_r   <= dmag_nxt;
    dneg_r   <= dneg_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    pt_r     <= pt_nxt;
    bx_r     <= bx_nxt;
    len_r    <= len_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    c_r      <= c_nxt;
    d_r      <= d_nxt;
    s_r      <= s_nxt;
    acc_r    <= acc_nxt;
    fc_r     <= fc_nxt;
    prod_r   <= prod_nxt;
    axis_r   <= axis_nxt;
    iter_r   <= iter_nxt;
    steps_r  <= steps_nxt;
    gap_ph_r <= gap_ph_nxt;
    gap_r    <= gap_nxt;
  end

  // Handshakes and result fields.
  assign in_req.ready        = (state_r == ST_IDLE);
  assign cfg_wr.ready        = 1'b1;
  assign out_rsp.valid       = (state_r == ST_OUT);
  assign out_rsp.box_point_x = bx_r[0];
  assign out_rsp.box_point_y = bx_r[1];
  assign out_rsp.box_point_z = bx_r[2];
  assign out_rsp.seg_point_x = pt_r[0];
  assign out_rsp.seg_point_y = pt_r[1];
  assign out_rsp.seg_point_z = pt_r[2];
  assign out_rsp.gap         = gap_r;

  `SBD_ASSERT_NEXT(a_accept_busy, in_req.valid && in_req.ready, state_r == ST_SQ_MUL,
    "request accepted but search did not start")
  `SBD_ASSERT_NOW(a_interval, state_r == ST_K_MUL, (a_r <= b_r) && (b_r <= len_r),
    "search interval out of order")
  `SBD_ASSERT_NOW(a_iter_bound, state_r == ST_K_MUL, iter_r < steps_r,
    "search step count overran its limit")

endmodule
`default_nettype wire

// File: dv/segment_box_distance_golden_test.sv
// Self-checking testbench for segment_box_distance_golden: directed table, an unused-index write, then random queries.
// Depends on sbd_pkg, the channel interfaces in sbd_channels.sv and the block itself.
`default_nettype none
module segment_box_distance_golden_test;
  import sbd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint vec3_t [3];

  typedef struct {
    logic signed [31:0] start [3];
    logic signed [31:0] stop  [3];
    logic signed [31:0] lower [3];
    logic signed [31:0] upper [3];
  } query_t;

  typedef struct {
    logic signed [31:0] box [3];
    logic signed [31:0] seg [3];
    logic        [31:0] gap;
  } answer_t;

  typedef struct {
    query_t  q;
    bit      known;
    answer_t a;
  } table_row_t;

  localparam logic [7:0] CFG_UNUSED = 8'd7;
  localparam int IDLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 200;
  localparam int NUM_PHASES = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sbd_in_if  in_req ();
  sbd_out_if out_rsp ();
  sbd_cfg_if cfg_wr ();

  segment_box_distance_golden i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .out_rsp(out_rsp),
    .cfg_wr (cfg_wr)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the two registers.
  logic [6:0]  iter_limit_q = 7'd50;
  logic [31:0] tolerance_q  = 32'd66;

  answer_t pending_answers [$];
  int      error_count = 0;
  int      idle_cycles = 0;
  bit      stall_on = 1'b0;
  logic [15:0] stall_pattern = 16'hFFFF;
  int      rx_cycle = 0;

  // Integer square root, floor, of a wide value.
  function automatic logic [63:0] wide_sqrt(logic [127:0] v);
    logic [63:0] res;
    logic [63:0] cand;
    res = '0;
    for (int i = 63; i >= 0; i--) begin
      cand = res | (64'd1 << i);
      if ({64'd0, cand} * {64'd0, cand} <= v) res = cand;
    end
    return res;
  endfunction

  function automatic logic [63:0] abs_diff(longint x, longint y);
    return (x >= y) ? 64'(x - y) : 64'(y - x);
  endfunction

  // Clamp a point to the box and return the squared distance to it.
  function automatic logic [127:0] clamp_to_box(vec3_t pt, vec3_t lo, vec3_t hi,
                                                output vec3_t bx);
    logic [127:0] acc;
    logic [63:0]  m;
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      bx[i] = pt[i];
      if (pt[i] > hi[i]) bx[i] = hi[i];
      else if (pt[i] < lo[i]) bx[i] = lo[i];
      m = abs_diff(pt[i], bx[i]);
      acc += {64'd0, m} * {64'd0, m};
    end
    return acc;
  endfunction

  // Point at arc length s along the segment, truncated toward the start.
  function automatic void point_at(vec3_t p, vec3_t dir, logic [63:0] s, logic [63:0] len,
                                   output vec3_t pt);
    logic [63:0]  m;
    logic [127:0] prod;
    longint       step;
    for (int i = 0; i < 3; i++) begin
      m = (dir[i] < 0) ? 64'(-dir[i]) : 64'(dir[i]);
      prod = ({64'd0, s} * {64'd0, m}) / {64'd0, len};
      step = longint'(prod[63:0]);
      pt[i] = (dir[i] < 0) ? p[i] - step : p[i] + step;
    end
  endfunction

  // Golden-section search for the segment point nearest the box.
  function automatic answer_t predict_distance(query_t q);
    vec3_t p1, dir, lo, hi, seg, bx, probe;
    logic [127:0] sq, fc, fd, sq_gap, kw;
    logic [63:0]  m, len, a, b, k, c, d, g;
    int steps;
    answer_t r;
    sq = '0;
    for (int i = 0; i < 3; i++) begin
      p1[i] = longint'(q.start[i]);
      dir[i] = longint'(q.stop[i]) - p1[i];
      lo[i] = longint'(q.lower[i]);
      hi[i] = longint'(q.upper[i]);
      m = (dir[i] < 0) ? 64'(-dir[i]) : 64'(dir[i]);
      sq += {64'd0, m} * {64'd0, m};
    end
    len = wide_sqrt(sq);
    if (len < {32'd0, tolerance_q} || len == 0) begin
      seg = p1;
    end else begin
      a = 0;
      b = len;
      steps = (iter_limit_q > ITER_BOUND) ? ITER_BOUND : int'(iter_limit_q);
      for (int n = 0; n < steps; n++) begin
        kw = {64'd0, b - a} * {94'd0, INVPHI_Q32};
        k = kw[95:32];
        c = b - k;
        d = a + k;
        point_at(p1, dir, c, len, probe);
        fc = clamp_to_box(probe, lo, hi, bx);
        point_at(p1, dir, d, len, probe);
        fd = clamp_to_box(probe, lo, hi, bx);
        if (fc < fd) b = d;
        else a = c;
        if (b - a < {32'd0, tolerance_q}) break;
      end
      point_at(p1, dir, (a + b) >> 1, len, seg);
    end
    sq_gap = clamp_to_box(seg, lo, hi, bx);
    g = wide_sqrt(sq_gap);
    if (g > 64'hFFFF_FFFF) g = 64'hFFFF_FFFF;
    for (int i = 0; i < 3; i++) begin
      r.box[i] = bx[i][31:0];
      r.seg[i] = seg[i][31:0];
    end
    r.gap = g[31:0];
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t mismatch %s: expected %h, actual %h", $realtime, name, exp_v, act_v);
      error_count++;
    end
  endfunction

  // Result checker: every taken response is compared with the oldest prediction.
  always @(posedge clk) begin
    answer_t e;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t unexpected response: gap %h", $realtime, out_rsp.gap);
        error_count++;
      end else begin
        e = pending_answers.pop_front();
        check_field("box_point_x", e.box[0], out_rsp.box_point_x);
        check_field("box_point_y", e.box[1], out_rsp.box_point_y);
        check_field("box_point_z", e.box[2], out_rsp.box_point_z);
        check_field("seg_point_x", e.seg[0], out_rsp.seg_point_x);
        check_field("seg_point_y", e.seg[1], out_rsp.seg_point_y);
        check_field("seg_point_z", e.seg[2], out_rsp.seg_point_z);
        check_field("gap", e.gap, out_rsp.gap);
      end
    end
  end

  // Watchdog on cycles in which no request moves on any channel.
  always @(posedge clk) begin
    if ((in_req.valid && in_req.ready) || (out_rsp.valid && out_rsp.ready) ||
        (cfg_wr.valid && cfg_wr.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t timeout, %0d responses outstanding", $realtime,
                 pending_answers.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Receiver: either always ready, or stalling on a rotating pattern.
  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1;
    out_rsp.ready <= stall_on ? stall_pattern[rx_cycle % 16] : 1'b1;
  end

  task automatic wait_idle();
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [7:0] index, logic [31:0] data);
    @(negedge clk);
    cfg_wr.valid = 1'b1;
    cfg_wr.index = index;
    cfg_wr.data  = data;
    do @(posedge clk); while (!cfg_wr.ready);
    if (index == CFG_ITER_LIMIT) iter_limit_q = data[6:0];
    else if (index == CFG_TOLERANCE) tolerance_q = data;
    @(negedge clk);
    cfg_wr.valid = 1'b0;
  endtask

  // Drive one query and wait until it is taken; the prediction is queued at that edge.
  task automatic send_query(query_t q, bit known, answer_t typed);
    @(negedge clk);
    in_req.valid   = 1'b1;
    in_req.start_x = q.start[0];
    in_req.start_y = q.start[1];
    in_req.start_z = q.start[2];
    in_req.end_x   = q.stop[0];
    in_req.end_y   = q.stop[1];
    in_req.end_z   = q.stop[2];
    in_req.lower_x = q.lower[0];
    in_req.lower_y = q.lower[1];
    in_req.lower_z = q.lower[2];
    in_req.upper_x = q.upper[0];
    in_req.upper_y = q.upper[1];
    in_req.upper_z = q.upper[2];
    do @(posedge clk); while (!in_req.ready);
    pending_answers.push_back(known ? typed : predict_distance(q));
  endtask

  task automatic pause_sender(int cycles);
    @(negedge clk);
    in_req.valid = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Coordinate at one of several scales, so that all bits get exercised.
  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
      2: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
      default: return $signed($urandom_range(0, 2000)) - 32'sd1000;
    endcase
  endfunction

  function automatic query_t rand_query();
    query_t q;
    int scale;
    if ($urandom_range(0, 9) == 0) begin
      // Raw noise: any box, inverted boxes included.
      for (int i = 0; i < 3; i++) begin
        q.start[i] = $urandom;
        q.stop[i]  = $urandom;
        q.lower[i] = $urandom;
        q.upper[i] = $urandom;
      end
    end else begin
      scale = $urandom_range(0, 3);
      for (int i = 0; i < 3; i++) begin
        q.start[i] = rand_coord();
        case (scale)
          0: q.stop[i] = q.start[i] + $signed($urandom_range(0, 200)) - 100;
          1: q.stop[i] = q.start[i] + $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
          default: q.stop[i] = rand_coord();
        endcase
        q.lower[i] = rand_coord();
        q.upper[i] = q.lower[i] + $signed($urandom_range(0, 32'h0080_0000));
        if ($urandom_range(0, 15) == 0) q.upper[i] = q.lower[i] - 1;
      end
    end
    return q;
  endfunction

  function automatic query_t make_query(logic signed [31:0] s, logic signed [31:0] e,
                                        logic signed [31:0] lo, logic signed [31:0] hi);
    query_t q;
    for (int i = 0; i < 3; i++) begin
      q.start[i] = s;
      q.stop[i]  = e;
      q.lower[i] = lo;
      q.upper[i] = hi;
    end
    return q;
  endfunction

  table_row_t stimulus_table [$];

  // Directed rows; results typed in only where they are obvious.
  task automatic build_table();
    table_row_t row;
    // Zero-length segment at the origin inside a unit box.
    row.q = make_query(0, 0, -32'sh10000, 32'sh10000);
    row.known = 1'b1;
    for (int i = 0; i < 3; i++) begin
      row.a.box[i] = 0;
      row.a.seg[i] = 0;
    end
    row.a.gap = 0;
    stimulus_table.push_back(row);
    // Zero-length segment one unit away from a point box on x.
    row.q = make_query(0, 0, 0, 0);
    row.q.start[0] = 32'sh10000;
    row.q.stop[0]  = 32'sh10000;
    row.a.seg[0] = 32'sh10000;
    row.a.gap = 32'h10000;
    stimulus_table.push_back(row);
    // Extreme corners: the distance saturates.
    row.q = make_query(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000);
    for (int i = 0; i < 3; i++) begin
      row.a.box[i] = 32'sh8000_0000;
      row.a.seg[i] = 32'sh7FFF_FFFF;
    end
    row.a.gap = 32'hFFFF_FFFF;
    stimulus_table.push_back(row);
    row.known = 1'b0;
    // Longest segment through a small box, both directions.
    stimulus_table.push_back('{make_query(32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd100, 32'sd100),
                               1'b0, row.a});
    stimulus_table.push_back('{make_query(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh1000, 32'sh2000),
                               1'b0, row.a});
    // Segment fully inside the box.
    stimulus_table.push_back('{make_query(-32'sh100, 32'sh100, -32'sh10000, 32'sh10000),
                               1'b0, row.a});
    // Segment just shorter than the default tolerance.
    stimulus_table.push_back('{make_query(32'sh50000, 32'sh50000 + 32'sd30, 0, 32'sh10000),
                               1'b0, row.a});
    // Inverted box on every axis.
    stimulus_table.push_back('{make_query(-32'sh30000, 32'sh30000, 32'sh20000, -32'sh20000),
                               1'b0, row.a});
    // Segment passing beside the box with mixed directions.
    row.q = make_query(32'sh40000, -32'sh40000, -32'sh10000, 32'sh10000);
    row.q.start[1] = 32'sh30000;
    row.q.stop[2]  = 32'sh7000_0000;
    stimulus_table.push_back(row);
    // Full-range box containing any segment.
    stimulus_table.push_back('{make_query(32'sh1234_5678, -32'sh0FED_CBA9, 32'sh8000_0000,
                                          32'sh7FFF_FFFF), 1'b0, row.a});
    // Point box with a long diagonal segment.
    stimulus_table.push_back('{make_query(-32'sh0100_0000, 32'sh0300_0000, 32'sh0010_0000,
                                          32'sh0010_0000), 1'b0, row.a});
    // All-ones and alternating-bit patterns in the endpoints against a thin box.
    stimulus_table.push_back('{make_query(-32'sd1, 32'sh5555_5555, 32'shAAAA_AAAA,
                                          32'shAAAA_AAAB), 1'b0, row.a});
  endtask

  int phase_iter  [NUM_PHASES] = '{0, 1, 2, 4, 8, 3, 64, 127, 5, 6};
  logic [31:0] phase_tol [NUM_PHASES] = '{32'd66, 32'd0, 32'h10000, 32'hFFFF_FFFF, 32'd1,
                                          32'd1000, 32'd66, 32'd0, 32'h8000_0000, 32'h400};
  int phase_items [NUM_PHASES] = '{150, 200, 200, 100, 150, 200, 15, 15, 160, 160};

  // Main sequence: reset, directed table at reset settings, an unused-index write, then random phases.
  initial begin
    answer_t none;
    int burst_left;
    in_req.valid = 1'b0;
    in_req.start_x = '0; in_req.start_y = '0; in_req.start_z = '0;
    in_req.end_x = '0;   in_req.end_y = '0;   in_req.end_z = '0;
    in_req.lower_x = '0; in_req.lower_y = '0; in_req.lower_z = '0;
    in_req.upper_x = '0; in_req.upper_y = '0; in_req.upper_z = '0;
    cfg_wr.valid = 1'b0;
    cfg_wr.index = '0;
    cfg_wr.data  = '0;
    out_rsp.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    build_table();
    foreach (stimulus_table[r]) begin
      send_query(stimulus_table[r].q, stimulus_table[r].known, stimulus_table[r].a);
      if ($urandom_range(0, 1) == 0) pause_sender($urandom_range(0, 4));
    end
    pause_sender(0);
    wait_idle();

    // A write to an unused index must leave both registers alone.
    write_register(CFG_UNUSED, $urandom);
    send_query(stimulus_table[3].q, 1'b0, none);
    pause_sender(0);
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_register(CFG_ITER_LIMIT, (32'(phase_iter[p]) & 32'h7F) | ($urandom & 32'hFFFF_FF80));
      write_register(CFG_TOLERANCE, phase_tol[p]);
      stall_on = (p % 3) != 0;
      // At least one ready slot per rotation, so the receiver never stalls for good.
      stall_pattern = 16'($urandom) | 16'h0001;
      burst_left = $urandom_range(1, 8);
      for (int n = 0; n < phase_items[p]; n++) begin
        send_query(rand_query(), 1'b0, none);
        burst_left--;
        if (burst_left == 0) begin
          pause_sender((p % 4 == 1) ? 0 : $urandom_range(0, 6));
          burst_left = $urandom_range(1, 8);
        end
      end
      pause_sender(0);
      wait_idle();
    end

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
